@@ hw/rtl/nfam_pkg.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - shared definitions
// Access codes, status codes, field widths and the command/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfam_pkg;

   // Field widths of the transaction payloads
   localparam int NF_ADDR_W   = 24;
   localparam int NF_DATA_W   = 32;
   // Word offset within a 24-bit byte space, and a count that can hold 2**22
   localparam int WORD_OFS_W  = 22;
   localparam int WORD_CNT_W  = 23;

   localparam logic [NF_DATA_W-1:0] ERASED_WORD = '1;

   typedef enum logic [1:0] {
      ACT_READ         = 2'd0,
      ACT_PROGRAM      = 2'd1,
      ACT_ERASE_SECTOR = 2'd2,
      ACT_ERASE_CHIP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MISALIGNED = 2'd1,
      ST_OUTSIDE    = 2'd2
   } status_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic       load_req;    // latch the request fields
      logic       mem_read;    // read the addressed word
      logic       prog_write;  // write back stored word AND program data
      logic       rdata_cap;   // capture read data for the response
      logic       div_init;    // multiply the offset by the sector reciprocal
      logic       div_step;    // scale the quotient estimate back to bytes
      logic       sect_latch;  // register the corrected sector start word
      logic       sweep_chip;  // set up an erase sweep over the whole array
      logic       sweep_sect;  // set up an erase sweep over one sector
      logic       sweep_write; // erase one word and advance the pointer
      logic       st_load;     // load the status code below
      status_type st_code;
      logic       rsp_load;    // move the finished result to the output
   } ctrl_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      action_type action;
      logic       misaligned;
      logic       below_base;
      logic       word_outside;
      logic       sect_outside;
      logic       sweep_last;
   } dp_stat_type;

endpackage

@@ hw/rtl/nfam_req_if.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - access request channel
// Valid/ready channel carrying one flash access per transaction.
// ----------------------------------------------------------------------------
interface nfam_req_if;
   import nfam_pkg::*;

   logic                 valid;
   logic                 ready;
   action_type           action;
   logic [NF_ADDR_W-1:0] byte_address;
   logic [NF_DATA_W-1:0] write_data;
   logic                 burst_end;

   modport source (output valid, output action, output byte_address,
                   output write_data, output burst_end, input ready);
   modport sink   (input valid, input action, input byte_address,
                   input write_data, input burst_end, output ready);
endinterface

@@ hw/rtl/nfam_rsp_if.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - access response channel
// Valid/ready channel carrying one result per access.
// ----------------------------------------------------------------------------
interface nfam_rsp_if;
   import nfam_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [NF_DATA_W-1:0] read_data;
   status_type           status;
   logic                 final_res;

   modport source (output valid, output read_data, output status,
                   output final_res, input ready);
   modport sink   (input valid, input read_data, input status,
                   input final_res, output ready);
endinterface

@@ hw/rtl/nfam_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module nfam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/nfam_dpath.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - datapath
// Request/base registers, address checks, sector rounding unit, erase
// sweep pointer, flash word store and the response output register.
// ----------------------------------------------------------------------------
module nfam_dpath #(
   parameter int ARRAY_WORDS  = 65536,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nfam_pkg::ctrl_cmd_type           cmd,
   output nfam_pkg::dp_stat_type            stat,
   input  logic                             csr_wr_en,
   input  logic [nfam_pkg::NF_ADDR_W-1:0]   csr_wr_data,
   input  nfam_pkg::action_type             req_action,
   input  logic [nfam_pkg::NF_ADDR_W-1:0]   req_byte_address,
   input  logic [nfam_pkg::NF_DATA_W-1:0]   req_write_data,
   input  logic                             req_burst_end,
   output logic [nfam_pkg::NF_DATA_W-1:0]   rsp_read_data,
   output nfam_pkg::status_type             rsp_status,
   output logic                             rsp_final_res
);
   import nfam_pkg::*;

   localparam int AW      = $clog2(ARRAY_WORDS);
   // 2**24 / sector size: the quotient estimate is exact or one short
   localparam int RECIP   = (1 << NF_ADDR_W) / SECTOR_BYTES;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int SECT_W  = $clog2(SECTOR_BYTES + 1);
   localparam int PROD_W  = NF_ADDR_W + RECIP_W;
   localparam int EST_W   = RECIP_W + SECT_W;
   localparam logic [WORD_CNT_W-1:0] ARRAY_WORDS_C = WORD_CNT_W'(ARRAY_WORDS);
   localparam logic [WORD_CNT_W-1:0] SECT_WORDS_C  = WORD_CNT_W'(SECTOR_BYTES / 4);
   localparam logic [RECIP_W-1:0]    RECIP_C       = RECIP_W'(RECIP);
   localparam logic [SECT_W-1:0]     SECTOR_C      = SECT_W'(SECTOR_BYTES);
   localparam logic [NF_ADDR_W-1:0]  SECT_BYTES_C  = NF_ADDR_W'(SECTOR_BYTES);

   // Registers
   action_type            act_ff, act_in;
   logic [NF_ADDR_W-1:0]  addr_ff, addr_in;
   logic [NF_DATA_W-1:0]  wdata_ff, wdata_in;
   logic                  last_ff, last_in;
   logic [NF_ADDR_W-1:0]  base_ff, base_in;
   logic [NF_DATA_W-1:0]  rdata_ff, rdata_in;
   status_type            status_ff, status_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [NF_ADDR_W-1:0]  est_bytes_ff, est_bytes_in;
   logic [WORD_OFS_W-1:0] sect_start_ff, sect_start_in;
   logic [WORD_CNT_W-1:0] ptr_ff, ptr_in;
   logic [WORD_CNT_W-1:0] limit_ff, limit_in;
   logic [NF_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Address arithmetic
   logic [NF_ADDR_W-1:0]  offset;
   logic [WORD_OFS_W-1:0] word_idx;
   logic [RECIP_W-1:0]    q_est;
   logic [EST_W-1:0]      est_full;
   logic [NF_ADDR_W-1:0]  rem_est;
   logic [NF_ADDR_W-1:0]  sect_bytes;
   logic [WORD_CNT_W-1:0] sect_end;
   logic [WORD_CNT_W-1:0] ptr_inc;

   // RAM ports
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [NF_DATA_W-1:0]  ram_wr_data;
   logic [NF_DATA_W-1:0]  ram_rd_data;

   assign offset     = addr_ff - base_ff;
   assign word_idx   = offset[NF_ADDR_W-1:2];
   assign q_est      = prod_ff[PROD_W-1:NF_ADDR_W];
   assign est_full   = q_est * SECTOR_C;
   // estimate may be one sector short; one compare and add corrects it
   assign rem_est    = offset - est_bytes_ff;
   assign sect_bytes = (rem_est >= SECT_BYTES_C) ? est_bytes_ff + SECT_BYTES_C
                                                 : est_bytes_ff;
   assign sect_end   = {1'b0, sect_start_ff} + SECT_WORDS_C;
   assign ptr_inc    = ptr_ff + 1'b1;

   // Status back to the controller
   always_comb begin
      stat.action       = act_ff;
      stat.misaligned   = (addr_ff[1:0] != 2'b00);
      stat.below_base   = (addr_ff < base_ff);
      stat.word_outside = ({1'b0, word_idx} >= ARRAY_WORDS_C);
      stat.sect_outside = ({1'b0, sect_start_ff} >= ARRAY_WORDS_C);
      stat.sweep_last   = (ptr_inc == limit_ff);
   end

   // Next-state logic
   always_comb begin
      act_in        = act_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      last_in       = last_ff;
      base_in       = csr_wr_en ? csr_wr_data : base_ff;
      rdata_in      = rdata_ff;
      status_in     = cmd.st_load ? cmd.st_code : status_ff;
      prod_in       = cmd.div_init ? offset * RECIP_C : prod_ff;
      est_bytes_in  = cmd.div_step ? est_full[NF_ADDR_W-1:0] : est_bytes_ff;
      sect_start_in = cmd.sect_latch ? sect_bytes[NF_ADDR_W-1:2] : sect_start_ff;
      ptr_in        = ptr_ff;
      limit_in      = limit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      // request capture; read data defaults to zero for every access
      if (cmd.load_req) begin
         act_in   = req_action;
         addr_in  = req_byte_address;
         wdata_in = req_write_data;
         last_in  = req_burst_end;
         rdata_in = '0;
      end
      if (cmd.rdata_cap) begin
         rdata_in = ram_rd_data;
      end

      // erase sweep pointer and end mark
      if (cmd.sweep_chip) begin
         ptr_in   = '0;
         limit_in = ARRAY_WORDS_C;
      end else if (cmd.sweep_sect) begin
         ptr_in   = {1'b0, sect_start_ff};
         limit_in = (sect_end > ARRAY_WORDS_C) ? ARRAY_WORDS_C : sect_end;
      end else if (cmd.sweep_write) begin
         ptr_in = ptr_inc;
      end

      // output register
      if (cmd.rsp_load) begin
         rsp_data_in   = rdata_ff;
         rsp_status_in = status_ff;
         rsp_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      wdata_ff      <= wdata_in;
      last_ff       <= last_in;
      rdata_ff      <= rdata_in;
      status_ff     <= status_in;
      prod_ff       <= prod_in;
      est_bytes_ff  <= est_bytes_in;
      sect_start_ff <= sect_start_in;
      ptr_ff        <= ptr_in;
      limit_ff      <= limit_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Flash word store: erase sweep or program write-back
   assign ram_wr_en   = cmd.sweep_write | cmd.prog_write;
   assign ram_wr_addr = cmd.sweep_write ? ptr_ff[AW-1:0] : word_idx[AW-1:0];
   assign ram_wr_data = cmd.sweep_write ? ERASED_WORD : (ram_rd_data & wdata_ff);

   nfam_ram #(
      .WIDTH (NF_DATA_W),
      .DEPTH (ARRAY_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (word_idx[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_final_res = rsp_last_ff;

   // Checks
   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_write |-> (ptr_ff < limit_ff))
      else $error("erase sweep pointer past its end mark");

   a_sect_rounding: assert property (@(posedge clock) disable iff (reset)
      cmd.sect_latch |-> ((offset - sect_bytes) < SECT_BYTES_C))
      else $error("sector start not within one sector of the offset");

   a_prog_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.prog_write |-> ({1'b0, word_idx} < ARRAY_WORDS_C))
      else $error("program write-back outside the array");

endmodule

@@ hw/rtl/nfam_ctrl.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - controller
// Sequences each access: checks, word read or read-modify-write, sector
// rounding, erase sweeps and the hand-off of the result to the output.
// ----------------------------------------------------------------------------
module nfam_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output nfam_pkg::ctrl_cmd_type cmd,
   input  nfam_pkg::dp_stat_type  stat
);
   import nfam_pkg::*;

   typedef enum logic [10:0] {
      S_INIT  = 11'b000_0000_0001,
      S_CLEAR = 11'b000_0000_0010,
      S_IDLE  = 11'b000_0000_0100,
      S_CHECK = 11'b000_0000_1000,
      S_RD    = 11'b000_0001_0000,
      S_PG    = 11'b000_0010_0000,
      S_DIV   = 11'b000_0100_0000,
      S_SECT  = 11'b000_1000_0000,
      S_SECT2 = 11'b001_0000_0000,
      S_SWEEP = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State machine and command decode
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.st_code  = ST_OK;

      case (state_ff)
         S_INIT: begin
            cmd.sweep_chip = 1'b1;
            state_in       = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.st_load = 1'b1;
            if (stat.action == ACT_ERASE_CHIP) begin
               cmd.sweep_chip = 1'b1;
               state_in       = S_SWEEP;
            end else if (stat.misaligned) begin
               cmd.st_code = ST_MISALIGNED;
               state_in    = S_DONE;
            end else if (stat.below_base) begin
               cmd.st_code = ST_OUTSIDE;
               state_in    = S_DONE;
            end else if (stat.action == ACT_ERASE_SECTOR) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else if (stat.word_outside) begin
               cmd.st_code = ST_OUTSIDE;
               state_in    = S_DONE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = (stat.action == ACT_READ) ? S_RD : S_PG;
            end
         end
         S_RD: begin
            cmd.rdata_cap = 1'b1;
            state_in      = S_DONE;
         end
         S_PG: begin
            cmd.prog_write = 1'b1;
            state_in       = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_SECT;
         end
         S_SECT: begin
            cmd.sect_latch = 1'b1;
            state_in       = S_SECT2;
         end
         S_SECT2: begin
            if (stat.sect_outside) begin
               cmd.st_load = 1'b1;
               cmd.st_code = ST_OUTSIDE;
               state_in    = S_DONE;
            end else begin
               cmd.sweep_sect = 1'b1;
               state_in       = S_SWEEP;
            end
         end
         S_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while one is in progress");

   a_prog_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.prog_write |-> $past(cmd.mem_read))
      else $error("program write-back without a preceding word read");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result loaded but not presented");

endmodule

@@ hw/rtl/nor_flash_array_model.sv @@
// ----------------------------------------------------------------------------
// NOR flash array model - top level
// Word-organised NOR flash array with read, program, sector and chip erase.
// ----------------------------------------------------------------------------
// The block holds ARRAY_WORDS 32-bit words and takes one access per
// transaction, returning exactly one result each. Addresses are byte
// addresses taken relative to the base written on the csr port. One access
// is handled at a time by a state machine over a word store with one write
// port, one read port and registered read; a program is a read, AND and
// write back. A sector erase first rounds the offset down to its sector
// start (reciprocal multiply, scale back, one correction), then writes one
// word per cycle; the sweep is clipped at the array end, and no word is
// written where the sector lies outside the array. A finished result
// waits in the done state until the output register is free.
// After reset the array is erased by a pass over all ARRAY_WORDS words
// during which no access is taken; base writes are taken throughout. A new
// access may be accepted while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module nor_flash_array_model #(
   parameter int ARRAY_WORDS  = 65536,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   nfam_req_if.sink                       req_ch,
   nfam_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [nfam_pkg::NF_ADDR_W-1:0] csr_wr_data
);
   import nfam_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer
   nfam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath and word store
   nfam_dpath #(
      .ARRAY_WORDS  (ARRAY_WORDS),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_action       (req_ch.action),
      .req_byte_address (req_ch.byte_address),
      .req_write_data   (req_ch.write_data),
      .req_burst_end    (req_ch.burst_end),
      .rsp_read_data    (rsp_ch.read_data),
      .rsp_status       (rsp_ch.status),
      .rsp_final_res    (rsp_ch.final_res)
   );

endmodule
